[src/fsks_pkg.sv]
// Shared constants, codes and command struct for the fixed-slot key/value store.
// Used by fsks_ctrl, fsks_datapath, the top level and its checker.
package fsks_pkg;

  localparam int SLOTS      = 16;
  localparam int KEY_BITS   = 64;
  localparam int VALUE_BITS = 64;
  localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  localparam int CMD_W      = 2;
  localparam int KEY_IN_W   = 64;
  localparam int VALUE_IN_W = 64;
  localparam int STATUS_W   = 2;
  localparam int INDEX_W    = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_FORGET = 2'd2,
    CMD_CLEAR  = 2'd3
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EXISTS    = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MARK_ERASED  = 2'd0,
    MARK_VALID   = 2'd1,
    MARK_DELETED = 2'd2,
    MARK_UNUSED  = 2'd3
  } mark_t;

  typedef struct packed {
    logic              load;
    logic              issue;
    logic [SLOT_W-1:0] addr;
    logic              commit;
  } dp_cmd_t;

endpackage

[src/fsks_ctrl.sv]
// Controller state machine: takes a word, sweeps every slot, then commits.
// Depends on fsks_pkg for the command struct and slot count.
module fsks_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fsks_pkg::dp_cmd_t dp_cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                      state;
  logic [fsks_pkg::SLOT_W-1:0] cnt;
  logic                        commit;

  assign in_ready = (state == S_IDLE);
  assign commit   = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    dp_cmd.load   = in_valid && in_ready;
    dp_cmd.issue  = (state == S_SCAN);
    dp_cmd.addr   = cnt;
    dp_cmd.commit = commit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= commit || (out_valid && !out_ready);
      case (state)
        S_IDLE: begin
          cnt <= '0;
          if (in_valid) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (cnt == fsks_pkg::SLOT_W'(fsks_pkg::SLOTS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[src/fsks_datapath.sv]
// Datapath: slot marks, key and value memories, scan compare and result register.
// Depends on fsks_pkg; driven by fsks_ctrl through dp_cmd.
module fsks_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fsks_pkg::dp_cmd_t                    dp_cmd,
  input  logic [fsks_pkg::CMD_W-1:0]           command,
  input  logic [fsks_pkg::KEY_IN_W-1:0]        key,
  input  logic [fsks_pkg::VALUE_IN_W-1:0]      value,
  output logic [fsks_pkg::STATUS_W-1:0]        status,
  output logic [fsks_pkg::INDEX_W-1:0]         slot_index,
  output logic [fsks_pkg::VALUE_IN_W-1:0]      read_value
);

  logic [fsks_pkg::KEY_BITS-1:0]   key_mem [fsks_pkg::SLOTS];
  logic [fsks_pkg::VALUE_BITS-1:0] val_mem [fsks_pkg::SLOTS];
  fsks_pkg::mark_t                 marks   [fsks_pkg::SLOTS];

  fsks_pkg::command_t              cmd_q;
  logic [fsks_pkg::KEY_BITS-1:0]   key_q;
  logic [fsks_pkg::VALUE_BITS-1:0] val_q;

  logic [fsks_pkg::KEY_BITS-1:0]   key_rd;
  logic [fsks_pkg::VALUE_BITS-1:0] val_rd;
  fsks_pkg::mark_t                 mark_rd;
  logic [fsks_pkg::SLOT_W-1:0]     addr_rd;
  logic                            cmp_vld;

  logic                            hit;
  logic [fsks_pkg::SLOT_W-1:0]     hit_idx;
  logic [fsks_pkg::VALUE_BITS-1:0] hit_val;
  logic                            free;
  logic [fsks_pkg::SLOT_W-1:0]     free_idx;

  logic                            wr_en;
  logic                            del_en;
  logic                            clr_en;
  fsks_pkg::status_t               status_next;
  logic [fsks_pkg::SLOT_W-1:0]     slot_next;
  logic                            rval_en;

  always_comb begin
    wr_en       = 1'b0;
    del_en      = 1'b0;
    clr_en      = 1'b0;
    rval_en     = 1'b0;
    status_next = fsks_pkg::ST_OK;
    slot_next   = '0;
    case (cmd_q)
      fsks_pkg::CMD_READ: begin
        if (hit) begin
          slot_next = hit_idx;
          rval_en   = 1'b1;
        end else begin
          status_next = fsks_pkg::ST_NOT_FOUND;
        end
      end
      fsks_pkg::CMD_WRITE: begin
        if (hit) begin
          status_next = fsks_pkg::ST_EXISTS;
          slot_next   = hit_idx;
        end else if (free) begin
          slot_next = free_idx;
          wr_en     = dp_cmd.commit;
        end else begin
          status_next = fsks_pkg::ST_FULL;
        end
      end
      fsks_pkg::CMD_FORGET: begin
        if (hit) begin
          slot_next = hit_idx;
          del_en    = dp_cmd.commit;
        end else begin
          status_next = fsks_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        clr_en = dp_cmd.commit;
      end
    endcase
  end

  // latch the word, then compare one slot per cycle behind the memory read
  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q <= fsks_pkg::command_t'(command);
      key_q <= key[fsks_pkg::KEY_BITS-1:0];
      val_q <= value[fsks_pkg::VALUE_BITS-1:0];
      hit   <= 1'b0;
      free  <= 1'b0;
    end else if (cmp_vld) begin
      if (!hit && mark_rd == fsks_pkg::MARK_VALID && key_rd == key_q) begin
        hit     <= 1'b1;
        hit_idx <= addr_rd;
        hit_val <= val_rd;
      end
      if (!free && mark_rd == fsks_pkg::MARK_ERASED) begin
        free     <= 1'b1;
        free_idx <= addr_rd;
      end
    end
    if (dp_cmd.issue) begin
      key_rd  <= key_mem[dp_cmd.addr];
      val_rd  <= val_mem[dp_cmd.addr];
      mark_rd <= marks[dp_cmd.addr];
      addr_rd <= dp_cmd.addr;
    end
    if (wr_en) begin
      key_mem[free_idx] <= key_q;
      val_mem[free_idx] <= val_q;
    end
    if (dp_cmd.commit) begin
      status     <= status_next;
      slot_index <= fsks_pkg::INDEX_W'(slot_next);
      read_value <= rval_en ? fsks_pkg::VALUE_IN_W'(hit_val) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_vld <= 1'b0;
      for (int i = 0; i < fsks_pkg::SLOTS; i++) begin
        marks[i] <= fsks_pkg::MARK_ERASED;
      end
    end else begin
      cmp_vld <= dp_cmd.issue;
      if (clr_en) begin
        for (int i = 0; i < fsks_pkg::SLOTS; i++) begin
          marks[i] <= fsks_pkg::MARK_ERASED;
        end
      end else if (wr_en) begin
        marks[free_idx] <= fsks_pkg::MARK_VALID;
      end else if (del_en) begin
        marks[hit_idx] <= fsks_pkg::MARK_DELETED;
      end
    end
  end

endmodule

[src/fixed_slot_key_value_store.sv]
// Top level of the fixed-slot key/value store: controller plus datapath.
// Depends on fsks_pkg, fsks_ctrl and fsks_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------------
//   in      | in_valid / in_ready  | command, key, value
//   out     | out_valid/ out_ready | status, slot_index, read_value
//
// Each word is accepted, then read slot by slot through the single key/value
// memory read port, then the compare stage drains and the result is committed.
// The result sits in an output register, so the next word is accepted while it
// waits; a further result holds in commit until the output is taken. Reset
// marks every slot erased at once.
module fixed_slot_key_value_store (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [fsks_pkg::CMD_W-1:0]      command,
  input  logic [fsks_pkg::KEY_IN_W-1:0]   key,
  input  logic [fsks_pkg::VALUE_IN_W-1:0] value,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fsks_pkg::STATUS_W-1:0]   status,
  output logic [fsks_pkg::INDEX_W-1:0]    slot_index,
  output logic [fsks_pkg::VALUE_IN_W-1:0] read_value
);

  fsks_pkg::dp_cmd_t dp_cmd;

  fsks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_cmd    (dp_cmd)
  );

  fsks_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .dp_cmd     (dp_cmd),
    .command    (command),
    .key        (key),
    .value      (value),
    .status     (status),
    .slot_index (slot_index),
    .read_value (read_value)
  );

endmodule

[src/fsks_checker.sv]
// Port-level checker for the fixed-slot key/value store, bound to the top level.
// Depends on fsks_pkg for the status codes.
module fsks_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [fsks_pkg::STATUS_W-1:0]   status,
  input logic [fsks_pkg::INDEX_W-1:0]    slot_index,
  input logic [fsks_pkg::VALUE_IN_W-1:0] read_value
);

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("word accepted while another is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot_index)
      && $stable(read_value))
    else $error("stalled result changed");

  a_value_only_on_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_value != '0 |-> status == fsks_pkg::ST_OK)
    else $error("read value on failed command");

  a_no_slot_on_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == fsks_pkg::ST_NOT_FOUND || status == fsks_pkg::ST_FULL)
      |-> slot_index == '0 && read_value == '0)
    else $error("slot or value reported on miss");

endmodule

bind fixed_slot_key_value_store fsks_checker u_fsks_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .slot_index (slot_index),
  .read_value (read_value)
);
